FILE: hw/rtl/vma_pkg.sv
// ----------------------------------------------------------------------------
// vma_pkg
// Shared types and fixed field widths of the vector moving average block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vma_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned LEN_IN_W  = 5;
  localparam int unsigned WIN_REG_W = 7;

  // op field codes
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_ABS,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

FILE: hw/rtl/vma_ram.sv
// ----------------------------------------------------------------------------
// vma_ram
// Generic single-port RAM with one write or registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                      wdata_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/vector_moving_average_top.sv
// ----------------------------------------------------------------------------
// vector_moving_average_top
// Per-element moving average over the last few result vectors.
// An element transfer passes through the read, update and abs states, the
//   radix-2 serial divider and the emit state to a valid result; with
//   window 0 it goes straight to emit and the value passes through. No new
//   item is taken until the previous result is in the output register.
// A clear item is taken in idle. Reset clears window, sums, pointers, counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_moving_average_top #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned CHANNELS_MAX = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [vma_pkg::WIN_REG_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic signed [vma_pkg::VALUE_W-1:0] value_i,
  input  logic [vma_pkg::LEN_IN_W-1:0]     vector_len_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [vma_pkg::VALUE_W-1:0] average_o,
  output logic                             last_of_vector_o
);

  localparam int unsigned VW      = vma_pkg::VALUE_W;
  localparam int unsigned SUM_W   = VW + $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SLOT_W  = $clog2(WINDOW_MAX);
  localparam int unsigned POS_W   = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;
  localparam int unsigned LEN_W   = $clog2(CHANNELS_MAX + 1);
  localparam int unsigned DEPTH   = WINDOW_MAX * CHANNELS_MAX;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DC_W    = $clog2(SUM_W);
  localparam int unsigned WCMP_W  = (CNT_W > vma_pkg::WIN_REG_W) ? CNT_W : vma_pkg::WIN_REG_W;
  localparam int unsigned LCMP_W  = (LEN_W > vma_pkg::LEN_IN_W) ? LEN_W : vma_pkg::LEN_IN_W;

  vma_pkg::state_e state_q, state_d;

  // control state
  logic [vma_pkg::WIN_REG_W-1:0] window_q;
  logic [CNT_W-1:0]              fill_q;
  logic [SLOT_W-1:0]             slot_q;
  logic [POS_W-1:0]              pos_q;
  logic [LEN_W-1:0]              stored_q;
  logic signed [SUM_W-1:0]       sums_q [CHANNELS_MAX];
  logic                          out_valid_q;
  logic [DC_W-1:0]               cnt_q;

  // datapath of the item in work
  logic signed [VW-1:0]          val_q;
  logic [POS_W-1:0]              cur_pos_q;
  logic                          full_q;
  logic [CNT_W-1:0]              div_q;
  logic                          last_q;
  logic [ADDR_W-1:0]             addr_q;
  logic signed [SUM_W-1:0]       acc_q;
  logic [SUM_W-1:0]              dvd_q;
  logic [CNT_W-1:0]              rem_q;
  logic                          sign_q;
  logic signed [VW-1:0]          average_q;
  logic                          last_out_q;

  // combinational
  logic [WCMP_W-1:0]  win_ext;
  logic [CNT_W-1:0]   win;
  logic [LCMP_W-1:0]  len_ext;
  logic [LEN_W-1:0]   len_c;
  logic               clr_len;
  logic [CNT_W-1:0]   eff_fill;
  logic [SLOT_W-1:0]  eff_slot;
  logic [LEN_W-1:0]   stored_eff;
  logic               is_last;
  logic               full;
  logic [CNT_W-1:0]   divisor;
  logic [ADDR_W-1:0]  addr;
  logic [CNT_W-1:0]   slot_inc;
  logic [SLOT_W-1:0]  slot_wrap;
  logic               in_fire;
  logic               elem_fire;
  logic               clr_fire;
  logic               clear_all;
  logic               out_free;
  logic               emit_load;
  logic               ram_en;
  logic               ram_we;
  logic [VW-1:0]      ram_rdata;
  logic signed [SUM_W-1:0] upd_sum;
  logic [CNT_W:0]     div_shift;
  logic               q_bit;
  logic [CNT_W-1:0]   rem_next;

  // window and length clamping, history clear on length change
  always_comb begin
    win_ext    = WCMP_W'(window_q);
    win        = (win_ext > WCMP_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(win_ext);
    len_ext    = LCMP_W'(vector_len_i);
    if (len_ext == '0) begin
      len_c = LEN_W'(1);
    end else if (len_ext > LCMP_W'(CHANNELS_MAX)) begin
      len_c = LEN_W'(CHANNELS_MAX);
    end else begin
      len_c = LEN_W'(len_ext);
    end
    clr_len    = (pos_q == '0) && (len_c != stored_q) && (win != '0) && (fill_q != '0);
    eff_fill   = clr_len ? '0 : fill_q;
    eff_slot   = clr_len ? '0 : slot_q;
    stored_eff = (pos_q == '0) ? len_c : stored_q;
    is_last    = ((LEN_W'(pos_q) + LEN_W'(1)) == stored_eff);
    full       = (eff_fill >= win);
    divisor    = full ? win : (eff_fill + CNT_W'(1));
    addr       = ADDR_W'(eff_slot) * ADDR_W'(CHANNELS_MAX) + ADDR_W'(pos_q);
    slot_inc   = CNT_W'(eff_slot) + CNT_W'(1);
    slot_wrap  = (slot_inc == win) ? '0 : SLOT_W'(slot_inc);
  end

  assign in_fire   = in_valid_i && in_ready_o;
  assign elem_fire = in_fire && (op_i != vma_pkg::OP_CLEAR);
  assign clr_fire  = in_fire && (op_i == vma_pkg::OP_CLEAR);
  assign clear_all = cfg_we_i || clr_fire || (elem_fire && clr_len);
  assign out_free  = !out_valid_q || out_ready_i;

  // drop the oldest entry once the window is full
  assign upd_sum = full_q ? (acc_q - {{(SUM_W-VW){ram_rdata[VW-1]}}, ram_rdata}) : acc_q;

  // one restoring division step
  always_comb begin
    div_shift = {rem_q, dvd_q[SUM_W-1]};
    q_bit     = (div_shift >= {1'b0, div_q});
    rem_next  = q_bit ? CNT_W'(div_shift - {1'b0, div_q}) : CNT_W'(div_shift);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vma_pkg::ST_IDLE: begin
        if (elem_fire) begin
          state_d = (win == '0) ? vma_pkg::ST_EMIT : vma_pkg::ST_READ;
        end
      end
      vma_pkg::ST_READ:   state_d = vma_pkg::ST_UPDATE;
      vma_pkg::ST_UPDATE: state_d = vma_pkg::ST_ABS;
      vma_pkg::ST_ABS:    state_d = vma_pkg::ST_DIV;
      vma_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = vma_pkg::ST_EMIT;
        end
      end
      vma_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = vma_pkg::ST_IDLE;
        end
      end
      default: state_d = vma_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    emit_load  = 1'b0;
    unique case (state_q)
      vma_pkg::ST_IDLE:   in_ready_o = 1'b1;
      vma_pkg::ST_READ:   ram_en = 1'b1;
      vma_pkg::ST_UPDATE: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      vma_pkg::ST_EMIT:   emit_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window register, pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      fill_q   <= '0;
      slot_q   <= '0;
      pos_q    <= '0;
      stored_q <= '0;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
      fill_q   <= '0;
      slot_q   <= '0;
      pos_q    <= '0;
    end else if (clr_fire) begin
      fill_q <= '0;
      slot_q <= '0;
      pos_q  <= '0;
    end else if (elem_fire) begin
      if (pos_q == '0) begin
        stored_q <= len_c;
      end
      pos_q <= is_last ? '0 : (pos_q + POS_W'(1));
      if (win != '0) begin
        if (is_last) begin
          slot_q <= slot_wrap;
          fill_q <= full ? eff_fill : (eff_fill + CNT_W'(1));
        end else begin
          slot_q <= eff_slot;
          fill_q <= eff_fill;
        end
      end
    end
  end

  // running sums per element position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS_MAX; i++) begin
        sums_q[i] <= '0;
      end
    end else if (clear_all) begin
      for (int i = 0; i < CHANNELS_MAX; i++) begin
        sums_q[i] <= '0;
      end
    end else if (state_q == vma_pkg::ST_UPDATE) begin
      sums_q[cur_pos_q] <= upd_sum;
    end
  end

  // division counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == vma_pkg::ST_ABS) begin
        cnt_q <= DC_W'(SUM_W - 1);
      end else if (state_q == vma_pkg::ST_DIV) begin
        cnt_q <= cnt_q - DC_W'(1);
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      vma_pkg::ST_IDLE: begin
        if (elem_fire) begin
          val_q     <= value_i;
          cur_pos_q <= pos_q;
          full_q    <= full;
          div_q     <= divisor;
          last_q    <= is_last;
          addr_q    <= addr;
          // pass-through: the value rides in the dividend register
          sign_q    <= 1'b0;
          dvd_q     <= {{(SUM_W-VW){1'b0}}, value_i};
        end
      end
      vma_pkg::ST_READ: begin
        acc_q <= sums_q[cur_pos_q] + {{(SUM_W-VW){val_q[VW-1]}}, val_q};
      end
      vma_pkg::ST_UPDATE: begin
        acc_q <= upd_sum;
      end
      vma_pkg::ST_ABS: begin
        sign_q <= acc_q[SUM_W-1];
        dvd_q  <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
        rem_q  <= '0;
      end
      vma_pkg::ST_DIV: begin
        dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
        rem_q <= rem_next;
      end
      vma_pkg::ST_EMIT: begin
        if (emit_load) begin
          average_q  <= sign_q ? (VW'(0) - dvd_q[VW-1:0]) : dvd_q[VW-1:0];
          last_out_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  vma_ram #(
    .Width (VW),
    .Depth (DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign average_o        = average_q;
  assign last_of_vector_o = last_out_q;

`ifndef SYNTHESIS
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vma_pkg::ST_DIV) |-> (div_q != '0))
    else $error("divisor is zero during division");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= win)
    else $error("fill count exceeds window");

  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win != '0) |-> (CNT_W'(slot_q) < win))
    else $error("slot pointer outside window");

  a_pos_in_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) || (LEN_W'(pos_q) < stored_q))
    else $error("element position beyond stored length");

  a_quotient_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vma_pkg::ST_EMIT) |-> (dvd_q[SUM_W-1:VW] == '0))
    else $error("quotient wider than the result field");
`endif

endmodule

FILE: dv/vector_moving_average_top_tb.sv
// ----------------------------------------------------------------------------
// vector_moving_average_top_tb
// Self-checking bench for the vector moving average block. Result vectors are
// fed element by element through the valid/ready input, and every output
// transfer is compared with a running model of the per-element window sums,
// fill count and slot pointer. The window register is rewritten between
// phases that vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_moving_average_top_tb;

  localparam int unsigned WIN_CAP      = 64;
  localparam int unsigned LANES        = 16;
  localparam int unsigned SETTLE       = 60;       // divider latency plus margin
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_ITEMS  = 190;
  localparam logic        OP_ELEMENT   = 1'b0;
  localparam logic [31:0] VALUE_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] VALUE_MIN    = 32'h8000_0000;

  logic                                  clk_i;
  logic                                  rst_ni;
  logic                                  cfg_we_i;
  logic [vma_pkg::WIN_REG_W-1:0]         cfg_wdata_i;
  logic                                  in_valid_i;
  logic                                  in_ready_o;
  logic                                  op_i;
  logic signed [vma_pkg::VALUE_W-1:0]    value_i;
  logic [vma_pkg::LEN_IN_W-1:0]          vector_len_i;
  logic                                  out_valid_o;
  logic                                  out_ready_i;
  logic signed [vma_pkg::VALUE_W-1:0]    average_o;
  logic                                  last_of_vector_o;

  // windowed mean per element position, one expectation per element item
  class vma_average_checker;
    typedef struct packed {
      logic signed [31:0] average;
      logic               is_last;
    } average_t;

    logic signed [31:0] history [WIN_CAP*LANES];
    longint             lane_sums [LANES];
    int unsigned        window_reg;
    int unsigned        fill_count;
    int unsigned        slot_ptr;
    int unsigned        stored_len;
    int unsigned        position;
    average_t           expected_averages [$];
    int unsigned        failures;

    function new();
      window_reg = 0;
      stored_len = 0;
      failures   = 0;
      clear_history();
    endfunction

    function void clear_history();
      foreach (lane_sums[i]) lane_sums[i] = 0;
      fill_count = 0;
      slot_ptr   = 0;
      position   = 0;
    endfunction

    function void write_window(logic [6:0] w);
      window_reg = w;
      clear_history();
    endfunction

    function int unsigned pending();
      return expected_averages.size();
    endfunction

    function void accept_item(logic op, logic signed [31:0] val, logic [4:0] len_raw);
      int unsigned win;
      int unsigned len;
      int unsigned pos;
      int unsigned slot;
      int unsigned idx;
      bit          is_last;
      bit          full;
      longint      divisor;
      longint      quotient;
      average_t    res;
      win = (window_reg > WIN_CAP) ? WIN_CAP : window_reg;
      if (op == vma_pkg::OP_CLEAR) begin
        clear_history();
        return;
      end
      if (len_raw == 0) len = 1;
      else if (len_raw > LANES) len = LANES;
      else len = len_raw;
      // length is latched on the first element only
      if (position == 0) begin
        if (len != stored_len && win != 0 && fill_count != 0) clear_history();
        stored_len = len;
      end
      if (position >= stored_len) position = 0;
      pos = position;
      is_last = (pos + 1 == stored_len);
      if (win == 0) begin
        quotient = val;
      end else begin
        slot = slot_ptr % win;
        idx  = slot * LANES + pos;
        full = (fill_count >= win);
        if (full) lane_sums[pos] -= longint'(history[idx]);
        lane_sums[pos] += longint'(val);
        history[idx] = val;
        divisor  = full ? longint'(win) : longint'(fill_count + 1);
        quotient = lane_sums[pos] / divisor;
        if (is_last) begin
          slot_ptr = (slot + 1) % win;
          if (!full) fill_count++;
        end
      end
      position = is_last ? 0 : pos + 1;
      res.average = quotient[31:0];
      res.is_last = is_last;
      expected_averages.insert(expected_averages.size(), res);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_average(logic signed [31:0] avg, logic is_last);
      average_t want;
      if (expected_averages.size() == 0) begin
        note_failure($sformatf("unexpected result: average %0d last %0b", avg, is_last));
        return;
      end
      want = expected_averages[0];
      expected_averages.delete(0);
      if (avg !== want.average || is_last !== want.is_last)
        note_failure($sformatf("expected average %0d last %0b, got average %0d last %0b",
                               want.average, want.is_last, avg, is_last));
    endfunction
  endclass

  vma_average_checker sb;
  int unsigned        sender_idle_pct;
  int unsigned        receiver_stall_pct;
  bit                 hold_off;
  int unsigned        cycle_count;

  vector_moving_average_top #(
    .WINDOW_MAX   (WIN_CAP),
    .CHANNELS_MAX (LANES)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .value_i          (value_i),
    .vector_len_i     (vector_len_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .average_o        (average_o),
    .last_of_vector_o (last_of_vector_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** vector_moving_average_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_average(average_o, last_of_vector_o);
  end

  // receiver: random stalls, or a long hold-off while the sender keeps offering
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) out_ready_i = 1'b0;
      else out_ready_i = ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [31:0] val, input logic [4:0] len);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    op_i         = op;
    value_i      = val;
    vector_len_i = len;
    do @(posedge clk_i); while (!in_ready_o);
    sb.accept_item(op, val, len);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // a trailing clear leaves no result behind, so give the block time
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [6:0] w);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = w;
    @(posedge clk_i);
    sb.write_window(w);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [4:0] rand_len(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady) return (r < 90) ? 5'($urandom_range(1, 2)) : 5'($urandom_range(0, 31));
    if (r < 55) return 5'($urandom_range(1, 3));
    if (r < 85) return 5'($urandom_range(4, 16));
    return 5'($urandom_range(0, 31));
  endfunction

  // well-formed vectors with random content, some noise and broken vectors
  task automatic run_phase(input int unsigned n_items, input bit steady, input bit squeeze);
    int unsigned sent;
    int unsigned n_elems;
    int unsigned clear_odds;
    int unsigned change_odds;
    logic [4:0]  cur_len;
    logic [4:0]  len_field;
    bit          held;
    sent        = 0;
    held        = 1'b0;
    clear_odds  = steady ? 400 : 60;
    change_odds = steady ? 50 : 8;
    cur_len     = rand_len(steady);
    while (sent < n_items) begin
      if ($urandom_range(1, change_odds) == 1) cur_len = rand_len(steady);
      if (cur_len == 0) n_elems = 1;
      else if (cur_len > LANES) n_elems = LANES;
      else n_elems = cur_len;
      for (int unsigned i = 0; i < n_elems; i++) begin
        if ($urandom_range(1, clear_odds) == 1) begin
          send_item(vma_pkg::OP_CLEAR, $urandom, 5'($urandom_range(0, 31)));
          sent++;
          break;
        end
        // later elements carry a length that must be ignored
        len_field = (i == 0 || $urandom_range(0, 4) != 0) ? cur_len
                                                            : 5'($urandom_range(0, 31));
        send_item(OP_ELEMENT, rand_value(), len_field);
        sent++;
        if (squeeze && !held && sent == 20) begin
          held = 1'b1;
          fork
            begin
              hold_off = 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk_i);
              hold_off = 1'b0;
            end
          join_none
        end
      end
    end
  endtask

  initial begin
    sb                 = new();
    cycle_count        = 0;
    hold_off           = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    op_i               = OP_ELEMENT;
    value_i            = '0;
    vector_len_i       = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // window 0 out of reset: pass-through, length clamps
    send_item(OP_ELEMENT, VALUE_MAX, 5'd0);
    send_item(OP_ELEMENT, VALUE_MIN, 5'd1);
    send_item(OP_ELEMENT, 32'hffff_ffff, 5'd31);
    send_item(vma_pkg::OP_CLEAR, 32'h0, 5'd0);

    // short window: sums beyond 32 bits, wrap, latch, length change, clear
    set_window(7'd3);
    for (int unsigned k = 0; k < 4; k++) begin
      send_item(OP_ELEMENT, VALUE_MAX, 5'd2);
      send_item(OP_ELEMENT, VALUE_MIN, (k == 0) ? 5'd5 : 5'd2);
    end
    send_item(OP_ELEMENT, -32'sd5, 5'd3);
    send_item(vma_pkg::OP_CLEAR, 32'hffff_ffff, 5'd31);
    send_item(OP_ELEMENT, -32'sd7, 5'd3);
    send_item(OP_ELEMENT, 32'sd7, 5'd3);
    send_item(OP_ELEMENT, 32'h0001_0000, 5'd3);

    set_window(7'd1);
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    set_window(7'd64);
    sender_idle_pct = 71;
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    set_window(7'd127);
    sender_idle_pct    = 0;
    receiver_stall_pct = 71;
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    set_window(7'd2);
    sender_idle_pct    = 19;
    receiver_stall_pct = 19;
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    set_window(7'($urandom_range(3, 63)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    set_window(7'd0);
    sender_idle_pct    = 19;
    receiver_stall_pct = 19;
    run_phase(PHASE_ITEMS, 1'b0, 1'b0);

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** vector_moving_average_top: PASSED **");
    end else begin
      $display("** vector_moving_average_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vma_pkg.sv
hw/rtl/vma_ram.sv
hw/rtl/vector_moving_average_top.sv
dv/vector_moving_average_top_tb.sv
